@@ design/sliding_window_zscore_normalizer_macros.svh @@
// assertion macros for the sliding window z-score normalizer
// no dependencies; included by the top level
`ifndef SLIDING_WINDOW_ZSCORE_NORMALIZER_MACROS_SVH
`define SLIDING_WINDOW_ZSCORE_NORMALIZER_MACROS_SVH
`ifndef SYNTH
`define SWZ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWZ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/swz_pkg.sv @@
// shared types and constants of the sliding window z-score normalizer
// no dependencies
package swz_pkg;

	localparam int MAX_AXES_DEF = 128;
	localparam int WINDOW_DEF = 32;

	localparam int AXIS_W = 7;
	localparam int RAW_W = 16;
	localparam int OUT_W = 16;

	localparam int PERIOD_W = 14;
	localparam int TICK_W = 10;
	localparam int NAXES_W = 8;
	localparam int ELAPSED_W = 15;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 15'h7FFF;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 14'd30;
	localparam logic [TICK_W-1:0] TICK_RST = 10'd2;
	localparam logic [NAXES_W-1:0] NAXES_RST = 8'd3;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_AXES = 2'd2;

	// round(1e-6 * 2^32)
	localparam longint unsigned EPS_COEF = 64'd4295;

	localparam int ROOT_W = 32;
	localparam int QUO_W = 17;
	localparam int FRAC_SH = 20;

	typedef struct packed {
		logic [AXIS_W-1:0] axis;
		logic signed [RAW_W-1:0] raw_value;
	} swz_in_t;

	typedef struct packed {
		logic [AXIS_W-1:0] axis_out;
		logic signed [OUT_W-1:0] normalized_value;
		logic last_of_frame;
	} swz_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_PREP,
		ST_VAR,
		ST_SQRT,
		ST_DIV_SETUP,
		ST_DIV,
		ST_FINISH
	} swz_state_t;

endpackage

@@ design/swz_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module swz_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/sliding_window_zscore_normalizer.sv @@
// an accepted transaction runs through read, update, prep, variance, the 32-step square
// root, divider setup, the 17-step divider (skipped when the quotient saturates) and
// finish; the next is taken only once finish hands its result to the output register,
// and finish waits while that register stays full; dropped or out-of-range ones are discarded in idle
// reset: asynchronous; then a clearing pass zeroes the rams
`include "sliding_window_zscore_normalizer_macros.svh"
// top level: window rams, running sums, iterative sqrt and divider
// depends on swz_pkg and swz_ram
module sliding_window_zscore_normalizer import swz_pkg::*; #(
	parameter int MAX_AXES = MAX_AXES_DEF,
	parameter int WINDOW = WINDOW_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input swz_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output swz_out_t out_data
);

	// sizes derived from the parameters
	localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam int PW = $clog2(WINDOW);
	localparam int WB = $clog2(WINDOW + 1);
	localparam int DEPTH = MAX_AXES * WINDOW;
	localparam int WAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = RAW_W + PW + 1;
	localparam int QW = 2 * RAW_W + PW;
	localparam int DW = QW + WB;
	localparam int NW = SW + 1;
	localparam int NUMW = NW + FRAC_SH + 1;
	localparam longint unsigned EPS_ADD = 64'(WINDOW) * 64'(WINDOW) * EPS_COEF;
	localparam logic signed [NW-1:0] WIN_S = NW'(WINDOW);
	localparam logic [WB-1:0] WIN_U = WB'(WINDOW);
	localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
	localparam logic [WAW-1:0] CLR_LAST = WAW'(DEPTH - 1);

	// sequencer
	swz_state_t state_q, state_d;

	// configuration registers
	logic [PERIOD_W-1:0] period_q;
	logic [TICK_W-1:0] tick_q;
	logic [NAXES_W-1:0] num_axes_q;

	// gate and ring state
	logic [ELAPSED_W-1:0] elapsed_q;
	logic frame_taken_q;
	logic [PW-1:0] wpos_q;
	logic [WAW-1:0] clr_cnt_q;

	// per-transaction datapath
	logic [AXW-1:0] axis_idx_q;
	logic [AXIS_W-1:0] axis_q;
	logic signed [RAW_W-1:0] raw_q;
	logic last_q;
	logic [WAW-1:0] addr_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0] sqs_q;
	logic [DW-1:0] wq_q;
	logic [2*SW-1:0] ss_q;
	logic signed [NW-1:0] num_q;
	logic [NW-1:0] mag_q;
	logic neg_q;
	logic [63:0] v_q;
	logic [63:0] root_q;
	logic [63:0] bit_q;
	logic [ROOT_W-1:0] s_q;
	logic [ROOT_W:0] rem_q;
	logic [QUO_W-1:0] numlo_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0] cnt_q;
	logic sat_q;

	// output register
	logic out_valid_q;
	swz_out_t out_q;

	// ram ports
	logic win_we;
	logic [WAW-1:0] win_waddr;
	logic [RAW_W-1:0] win_wdata;
	logic [RAW_W-1:0] win_rdata;
	logic sum_we;
	logic [AXW-1:0] sum_waddr;
	logic [SW+QW-1:0] sum_wdata;
	logic [SW+QW-1:0] sum_rdata;

	// combinational helpers
	logic [NAXES_W-1:0] n_eff;
	logic accept;
	logic in_range;
	logic gate_drop;
	logic taken_next;
	logic go;
	logic [ELAPSED_W:0] elapsed_add;
	logic signed [RAW_W-1:0] old_val;
	logic signed [SW-1:0] sum_old;
	logic [QW-1:0] sqs_old;
	logic signed [2*RAW_W-1:0] rr;
	logic signed [2*RAW_W-1:0] oo;
	logic signed [SW-1:0] sum_new;
	logic [QW-1:0] sqs_new;
	logic [DW-1:0] var_d;
	logic [63:0] trial;
	logic [ROOT_W-1:0] s_fix;
	logic [NUMW-1:0] numer;
	logic [NUMW-QUO_W-1:0] numer_hi;
	logic div_sat;
	logic [ROOT_W:0] rem_sh;
	logic rem_ge;
	logic signed [OUT_W-1:0] z_val;

	assign n_eff = (num_axes_q > NAXES_W'(MAX_AXES)) ? NAXES_W'(MAX_AXES) : num_axes_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign in_range = {1'b0, in_data.axis} < n_eff;

	// decimation gate runs on axis 0 only
	assign gate_drop = (in_data.axis == '0) && (elapsed_q < {1'b0, period_q});
	assign taken_next = (in_data.axis == '0) ? !gate_drop : frame_taken_q;
	assign go = accept && taken_next && in_range;
	assign elapsed_add = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(tick_q);

	// running sum update from the old slot value
	assign old_val = win_rdata;
	assign sum_old = sum_rdata[SW+QW-1:QW];
	assign sqs_old = sum_rdata[QW-1:0];
	assign rr = raw_q * raw_q;
	assign oo = old_val * old_val;
	assign sum_new = sum_old + SW'(raw_q) - SW'(old_val);
	assign sqs_new = sqs_old + QW'($unsigned(rr)) - QW'($unsigned(oo));

	// population variance scaled by W^2; the epsilon term is added in ST_VAR
	assign var_d = wq_q - DW'(ss_q);

	// one square root step per cycle
	assign trial = root_q + bit_q;

	// divider setup: the top bits tell if the quotient overflows 17 bits
	assign s_fix = (root_q[ROOT_W-1:0] == '0) ? ROOT_W'(1) : root_q[ROOT_W-1:0];
	assign numer = (NUMW'(mag_q) << FRAC_SH) + NUMW'(s_fix >> 1);
	assign numer_hi = numer[NUMW-1:QUO_W];
	// compare at root width, the root can be wider than the top bits
	assign div_sat = ROOT_W'(numer_hi) >= s_fix;

	// one restoring division step per cycle
	assign rem_sh = {rem_q[ROOT_W-1:0], numlo_q[QUO_W-1]};
	assign rem_ge = rem_sh >= {1'b0, s_q};

	// saturate to q4.12 with the sign of the numerator
	always_comb begin
		if (neg_q) begin
			if (sat_q || quo_q > QUO_W'(32768)) begin
				z_val = -16'sd32768;
			end else begin
				z_val = OUT_W'(-$signed({1'b0, quo_q}));
			end
		end else begin
			if (sat_q || quo_q > QUO_W'(32767)) begin
				z_val = 16'sd32767;
			end else begin
				z_val = OUT_W'(quo_q);
			end
		end
	end

	// ram write muxes; the clearing pass owns the write ports
	always_comb begin
		if (state_q == ST_CLEAR) begin
			win_we = 1'b1;
			win_waddr = clr_cnt_q;
			win_wdata = '0;
			sum_we = 1'b1;
			sum_waddr = AXW'(clr_cnt_q);
			sum_wdata = '0;
		end else begin
			win_we = (state_q == ST_UPDATE);
			win_waddr = addr_q;
			win_wdata = raw_q;
			sum_we = (state_q == ST_UPDATE);
			sum_waddr = axis_idx_q;
			sum_wdata = {sum_new, sqs_new};
		end
	end

	swz_ram #(
		.WIDTH(RAW_W),
		.DEPTH(DEPTH)
	) u_win_ram (
		.clk(clk),
		.we(win_we),
		.waddr(win_waddr),
		.wdata(win_wdata),
		.raddr(addr_q),
		.rdata(win_rdata)
	);

	swz_ram #(
		.WIDTH(SW + QW),
		.DEPTH(MAX_AXES)
	) u_sum_ram (
		.clk(clk),
		.we(sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.raddr(axis_idx_q),
		.rdata(sum_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (go) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_PREP;
			ST_PREP: state_d = ST_VAR;
			ST_VAR: state_d = ST_SQRT;
			ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = ST_DIV_SETUP;
				end
			end
			ST_DIV_SETUP: begin
				if (div_sat) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration writes, any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			tick_q <= TICK_RST;
			num_axes_q <= NAXES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				CFG_TICK: tick_q <= cfg_data[TICK_W-1:0];
				CFG_NUM_AXES: num_axes_q <= cfg_data[NAXES_W-1:0];
				default: ;
			endcase
		end
	end

	// control state: gate timer, ring position, clear counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			frame_taken_q <= 1'b0;
			wpos_q <= '0;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + WAW'(1);
			end
			if (accept && in_data.axis == '0) begin
				frame_taken_q <= !gate_drop;
				if (gate_drop) begin
					elapsed_q <= elapsed_add[ELAPSED_W] ? ELAPSED_MAX :
						elapsed_add[ELAPSED_W-1:0];
				end else begin
					elapsed_q <= '0;
				end
			end
			// ring advances once the last axis of a frame is written
			if (state_q == ST_UPDATE && last_q) begin
				wpos_q <= (wpos_q == POS_LAST) ? '0 : wpos_q + PW'(1);
			end
			if (state_q == ST_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, stepped by the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					axis_q <= in_data.axis;
					axis_idx_q <= AXW'(in_data.axis);
					raw_q <= in_data.raw_value;
					last_q <= ({1'b0, in_data.axis} == n_eff - NAXES_W'(1));
					addr_q <= WAW'(AXW'(in_data.axis)) * WAW'(WINDOW) + WAW'(wpos_q);
				end
			end
			ST_UPDATE: begin
				sum_q <= sum_new;
				sqs_q <= sqs_new;
			end
			ST_PREP: begin
				wq_q <= DW'(sqs_q) * DW'(WIN_U);
				ss_q <= $unsigned((2*SW)'(sum_q) * (2*SW)'(sum_q));
				num_q <= NW'(raw_q) * WIN_S - NW'(sum_q);
			end
			ST_VAR: begin
				v_q <= (64'(var_d) << 16) + EPS_ADD;
				neg_q <= num_q[NW-1];
				mag_q <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
				root_q <= '0;
				bit_q <= 64'(1) << 62;
			end
			ST_SQRT: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV_SETUP: begin
				s_q <= s_fix;
				sat_q <= div_sat;
				rem_q <= (ROOT_W + 1)'(numer_hi);
				numlo_q <= numer[QUO_W-1:0];
				quo_q <= '0;
				cnt_q <= 5'(QUO_W - 1);
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_sh - {1'b0, s_q} : rem_sh;
				quo_q <= {quo_q[QUO_W-2:0], rem_ge};
				numlo_q <= numlo_q << 1;
				cnt_q <= cnt_q - 5'd1;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_q.axis_out <= axis_q;
					out_q.normalized_value <= z_val;
					out_q.last_of_frame <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// the square root walks one bit pair per step
	`SWZ_ASSERT(a_sqrt_bit_onehot, clk, arst_n, (state_q == ST_SQRT) |-> $onehot(bit_q), "sqrt step bit not one-hot")
	// last sqrt step hands over to the divider
	`SWZ_ASSERT_NEXT(a_sqrt_to_div, clk, arst_n, state_q == ST_SQRT && bit_q[0], state_q == ST_DIV_SETUP, "sqrt did not end in divider setup")
	// partial remainder stays below the divisor
	`SWZ_ASSERT(a_div_rem, clk, arst_n, (state_q == ST_DIV) |-> (rem_q < {1'b0, s_q}), "divider remainder out of range")
	// end of frame flag matches the configured axis count
	`SWZ_ASSERT(a_last_axis, clk, arst_n, (out_valid && out_data.last_of_frame) |-> ({1'b0, out_data.axis_out} == n_eff - NAXES_W'(1)), "last_of_frame on wrong axis")

endmodule

@@ tb/sliding_window_zscore_normalizer_test.sv @@
// self-checking testbench of the sliding window z-score normalizer
// depends on swz_pkg and the block; predicts results with its own window and sums
module sliding_window_zscore_normalizer_test;
	import swz_pkg::*;

	localparam int NAXES = 128;
	localparam int WIN = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	swz_in_t in_data;
	logic out_valid;
	logic out_ready;
	swz_out_t out_data;

	sliding_window_zscore_normalizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// predictor state
	logic [PERIOD_W-1:0] period_reg;
	logic [TICK_W-1:0] tick_reg;
	logic [NAXES_W-1:0] naxes_reg;
	logic signed [15:0] ring [NAXES*WIN];
	int unsigned slot;
	longint axis_sum [NAXES];
	longint unsigned axis_sq_sum [NAXES];
	int unsigned elapsed;
	bit frame_open;

	swz_out_t zscore_queue[$];
	int mismatches;
	int failed;
	int idle_cycles;
	int send_idle_pct;
	int stall_pct;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// runs one accepted transaction through the predictor
	task automatic predict_zscore(input swz_in_t t);
		int unsigned n, ax, idx;
		longint r, old, num, s_sum;
		longint unsigned s_abs, d, v, s, mag, q;
		bit neg, last;
		swz_out_t res;
		ax = t.axis;
		r = t.raw_value;
		n = (naxes_reg > NAXES) ? NAXES : naxes_reg;
		if (ax == 0) begin
			// decimation gate at frame start
			if (elapsed < period_reg) begin
				elapsed = elapsed + tick_reg;
				if (elapsed > 32767) elapsed = 32767;
				frame_open = 0;
				return;
			end
			elapsed = 0;
			frame_open = 1;
		end
		if (!frame_open || ax >= n) return;
		idx = ax * WIN + slot;
		old = ring[idx];
		ring[idx] = 16'(r);
		axis_sum[ax] += r - old;
		axis_sq_sum[ax] = axis_sq_sum[ax] + longint'(r * r) - longint'(old * old);
		last = (ax == n - 1);
		if (last) slot = (slot + 1) % WIN;
		s_sum = axis_sum[ax];
		s_abs = s_sum < 0 ? -s_sum : s_sum;
		d = WIN * axis_sq_sum[ax] - s_abs * s_abs;
		v = (d << 16) + WIN * WIN * EPS_COEF;
		s = int_sqrt(v);
		if (s == 0) s = 1;
		num = WIN * r - s_sum;
		neg = num < 0;
		mag = neg ? -num : num;
		q = ((mag << 20) + (s >> 1)) / s;
		res.axis_out = AXIS_W'(ax);
		if (neg) res.normalized_value = 16'((q > 32768) ? -32768 : -longint'(q));
		else res.normalized_value = 16'((q > 32767) ? 32767 : q);
		res.last_of_frame = last;
		zscore_queue.insert(zscore_queue.size(), res);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// output side: random stall and comparison against the oldest expectation
	always @(posedge clk) begin
		swz_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (zscore_queue.size() == 0) begin
					failed = 1;
					if (mismatches < 10)
						$display("unexpected result axis %0d value %0d",
							out_data.axis_out, out_data.normalized_value);
					mismatches++;
				end else begin
					want = zscore_queue.pop_front();
					if (want !== out_data) begin
						failed = 1;
						if (mismatches < 10)
							$display("mismatch: expected axis %0d z %0d last %0d, got axis %0d z %0d last %0d",
								want.axis_out, want.normalized_value, want.last_of_frame,
								out_data.axis_out, out_data.normalized_value,
								out_data.last_of_frame);
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog: cycles in which no transaction moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("sliding_window_zscore_normalizer test failed");
				$finish;
			end
		end
	end

	// sends one transaction, idling first at the phase's rate
	// valid stays up after the accepting edge until the next send, idle or drain
	task automatic send_sample(input logic [AXIS_W-1:0] ax, input logic signed [15:0] raw);
		swz_in_t t;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		t.axis = ax;
		t.raw_value = raw;
		in_valid <= 1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_zscore(t);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (zscore_queue.size() != 0) @(posedge clk);
		// dropped transactions may still be finishing
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input int unsigned val);
		cfg_we <= 1;
		cfg_index <= i;
		cfg_data <= CFG_DATA_W'(val);
		if (i == CFG_SAMPLE_PERIOD) period_reg = PERIOD_W'(val);
		else if (i == CFG_TICK) tick_reg = TICK_W'(val);
		else naxes_reg = NAXES_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// sends one frame of axes 0..cnt-1 with random values
	task automatic send_frame(input int cnt);
		for (int a = 0; a < cnt; a++) send_sample(AXIS_W'(a), 16'($urandom));
	endtask

	// directed table: axis, raw, check, expected z
	typedef struct {
		int ax;
		int raw;
		bit known;
		int z;
	} stim_row_t;
	stim_row_t dir_rows[] = '{
		'{0, 0, 1, 0},          // first frame taken, all zero window gives z 0
		'{1, 32767, 0, 0},
		'{2, -32768, 0, 0},
		'{0, 100, 0, 0},        // dropped by the gate
		'{1, 5, 0, 0},
		'{0, -1, 0, 0},
		'{0, 32767, 0, 0},      // repeated frame starts
		'{1, 32767, 0, 0},
		'{1, -32768, 0, 0},     // repeated axis overwrites
		'{2, 1, 0, 0},
		'{5, 7, 0, 0},          // axis out of range
		'{127, -7, 0, 0},
		'{0, -32768, 0, 0},
		'{2, 32767, 0, 0}
	};

	initial begin
		int rnd, phase;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_SAMPLE_PERIOD;
		cfg_data = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		mismatches = 0;
		failed = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		period_reg = PERIOD_RST;
		tick_reg = TICK_RST;
		naxes_reg = NAXES_RST;
		foreach (ring[i]) ring[i] = 0;
		foreach (axis_sum[i]) begin
			axis_sum[i] = 0;
			axis_sq_sum[i] = 0;
		end
		slot = 0;
		elapsed = 0;
		frame_open = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// a long tick lets the second frame start through the gate
		write_reg(CFG_TICK, 1000);
		write_reg(CFG_SAMPLE_PERIOD, 1);
		// values before any frame are dropped
		send_sample(1, 123);
		send_sample(0, 0);
		// period 30 with the long tick drops every other frame start
		foreach (dir_rows[i]) begin
			if (i == 3) begin
				drain();
				write_reg(CFG_SAMPLE_PERIOD, 30);
			end
			if (i == 6) begin
				drain();
				write_reg(CFG_SAMPLE_PERIOD, 1);
				write_reg(CFG_TICK, 1000);
			end
			if (dir_rows[i].known && zscore_queue.size() == 0) begin
				send_sample(AXIS_W'(dir_rows[i].ax), 16'(dir_rows[i].raw));
				if (zscore_queue.size() == 0 || zscore_queue[$].normalized_value != dir_rows[i].z)
					failed = 1;
			end else begin
				send_sample(AXIS_W'(dir_rows[i].ax), 16'(dir_rows[i].raw));
			end
		end
		drain();
		// long decimation gaps: long period with a tick of 1000
		write_reg(CFG_SAMPLE_PERIOD, 10000);
		write_reg(CFG_TICK, 1000);
		for (int k = 0; k < 12; k++) send_sample(0, 16'(k));
		drain();
		write_reg(CFG_NUM_AXES, 0);  // no axis in range
		send_sample(0, 9);
		send_sample(0, 9);
		drain();

		// random phases over idle patterns and settings
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 73; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 73; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			write_reg(CFG_SAMPLE_PERIOD, (phase == 7) ? 16383 : $urandom_range(1, 4));
			write_reg(CFG_TICK, (phase == 5) ? 0 : $urandom_range(1, 1000));
			write_reg(CFG_NUM_AXES, (phase == 6) ? 128 : (phase == 3) ? 255 : $urandom_range(1, 6));
			rnd = 0;
			while (rnd < 125) begin
				if ($urandom_range(9) < 8) begin
					// well-formed frame, sometimes short
					int cnt;
					cnt = (naxes_reg > 8) ? 3 : naxes_reg;
					if ($urandom_range(7) == 0) cnt = $urandom_range(1, cnt);
					send_frame(cnt);
					rnd += cnt;
				end else begin
					send_sample(AXIS_W'($urandom_range(127)), 16'($urandom));
					rnd++;
				end
				if (rnd % 50 == 0) drain();
			end
			if (phase == 6) begin
				// wide frame reaching the top axis
				for (int a = 0; a < 128; a += 9) send_sample(AXIS_W'(a), 16'($urandom));
				send_sample(127, 16'($urandom));
			end
			drain();
		end

		if (failed == 0)
			$display("sliding_window_zscore_normalizer test passed");
		else
			$display("sliding_window_zscore_normalizer test failed");
		$finish;
	end
endmodule
